@@ hw/rtl/sbi_pkg.sv @@
package sbi_pkg;

    // Default coordinate width (signed Q(n-16).16)
    localparam int COORD_BITS_DEF = 32;

    // Depth of the queue between classifier and arithmetic
    localparam int QUEUE_DEPTH = 4;

    // Configuration register indexes
    localparam logic [1:0] REG_BOX_LEFT   = 2'd0;
    localparam logic [1:0] REG_BOX_BOTTOM = 2'd1;
    localparam logic [1:0] REG_BOX_WIDTH  = 2'd2;
    localparam logic [1:0] REG_BOX_HEIGHT = 2'd3;

    // Candidate lanes, in the order they are tried
    localparam int LANES = 4;

endpackage

@@ hw/rtl/sbi_if.sv @@
interface sbi_seg_if #(parameter int W = 32);
    logic         valid;
    logic         ready;
    logic [W-1:0] start_x;
    logic [W-1:0] start_y;
    logic [W-1:0] end_x;
    logic [W-1:0] end_y;

    modport source (output valid, start_x, start_y, end_x, end_y, input ready);
    modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface sbi_hit_if #(parameter int W = 32);
    logic         valid;
    logic         ready;
    logic [1:0]   point_count;
    logic [W-1:0] first_x;
    logic [W-1:0] first_y;
    logic [W-1:0] second_x;
    logic [W-1:0] second_y;

    modport source (output valid, point_count, first_x, first_y, second_x, second_y,
                    input ready);
    modport sink   (input valid, point_count, first_x, first_y, second_x, second_y,
                    output ready);
endinterface

interface sbi_cfg_if #(parameter int W = 32);
    logic         valid;
    logic         ready;
    logic [1:0]   index;
    logic [W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ hw/rtl/sbi_queue.sv @@
module sbi_queue
    import sbi_pkg::*;
#(
    parameter int DW    = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [DW-1:0] i_data,
    output logic          o_not_full,
    input  logic          i_pop,
    output logic          o_not_empty,
    output logic [DW-1:0] o_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [DW-1:0] r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic          w_push;
    logic          w_pop;

    assign o_not_full  = (r_cnt != CW'(DEPTH));
    assign o_not_empty = (r_cnt != '0);
    assign o_data      = r_mem[r_rd];
    assign w_push      = i_push && o_not_full;
    assign w_pop       = i_pop && o_not_empty;

    // Store entries
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end
endmodule

@@ hw/rtl/sbi_front.sv @@
module sbi_front
    import sbi_pkg::*;
#(
    parameter int W  = COORD_BITS_DEF,
    parameter int JW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sbi_seg_if.sink       i_seg,
    input  logic [W-1:0]  i_left,
    input  logic [W-1:0]  i_bottom,
    input  logic [W-2:0]  i_width,
    input  logic [W-2:0]  i_height,
    output logic          o_valid,
    output logic [JW-1:0] o_job,
    input  logic          i_ready
);
    localparam int A = W + 1;

    typedef struct packed {
        logic [LANES-1:0]        ok;
        logic [LANES-1:0]        neg;
        logic [LANES-1:0][A-1:0] off;
        logic [LANES-1:0][W:0]   bnd;
        logic [A-1:0]            dxm;
        logic [A-1:0]            dym;
        logic [W-1:0]            sx;
        logic [W-1:0]            sy;
        logic [W-1:0]            minx;
        logic [W-1:0]            maxx;
        logic [W-1:0]            miny;
        logic [W-1:0]            maxy;
    } t_job;

    logic               r_fv;
    t_job               r_job;
    t_job               n_job;
    logic signed [W:0]  w_sx, w_sy, w_ex, w_ey, w_dx, w_dy;
    logic signed [W:0]  w_minx, w_maxx, w_miny, w_maxy;
    logic signed [W:0]  w_bnd [LANES];
    logic signed [W+1:0] w_off [LANES];
    logic               w_accept;

    assign i_seg.ready = !r_fv || i_ready;
    assign w_accept    = i_seg.valid && i_seg.ready;
    assign o_valid     = r_fv;
    assign o_job       = JW'(r_job);

    // Classify the segment: deltas, span and one candidate per box edge
    always_comb begin
        w_sx = $signed({i_seg.start_x[W-1], i_seg.start_x});
        w_sy = $signed({i_seg.start_y[W-1], i_seg.start_y});
        w_ex = $signed({i_seg.end_x[W-1], i_seg.end_x});
        w_ey = $signed({i_seg.end_y[W-1], i_seg.end_y});
        w_dx = w_ex - w_sx;
        w_dy = w_ey - w_sy;
        w_minx = (w_sx < w_ex) ? w_sx : w_ex;
        w_maxx = (w_sx < w_ex) ? w_ex : w_sx;
        w_miny = (w_sy < w_ey) ? w_sy : w_ey;
        w_maxy = (w_sy < w_ey) ? w_ey : w_sy;
        w_bnd[0] = $signed({i_left[W-1], i_left});
        w_bnd[1] = $signed({i_left[W-1], i_left}) + $signed({2'b00, i_width});
        w_bnd[2] = $signed({i_bottom[W-1], i_bottom});
        w_bnd[3] = $signed({i_bottom[W-1], i_bottom}) + $signed({2'b00, i_height});

        n_job = '0;
        for (int k = 0; k < LANES; k++) begin
            if (k < 2) begin
                w_off[k] = {w_bnd[k][W], w_bnd[k]} - {w_sx[W], w_sx};
                n_job.ok[k]  = (w_dx != 0) && (w_bnd[k] >= w_minx) && (w_bnd[k] <= w_maxx);
                n_job.neg[k] = w_off[k][W+1] ^ w_dy[W] ^ w_dx[W];
            end else begin
                w_off[k] = {w_bnd[k][W], w_bnd[k]} - {w_sy[W], w_sy};
                n_job.ok[k]  = (w_dy != 0) && (w_bnd[k] >= w_miny) && (w_bnd[k] <= w_maxy);
                n_job.neg[k] = w_off[k][W+1] ^ w_dx[W] ^ w_dy[W];
            end
            n_job.off[k] = w_off[k][W+1] ? A'(-w_off[k]) : A'(w_off[k]);
            n_job.bnd[k] = w_bnd[k];
        end
        n_job.dxm  = w_dx[W] ? A'(-w_dx) : A'(w_dx);
        n_job.dym  = w_dy[W] ? A'(-w_dy) : A'(w_dy);
        n_job.sx   = i_seg.start_x;
        n_job.sy   = i_seg.start_y;
        n_job.minx = W'(w_minx);
        n_job.maxx = W'(w_maxx);
        n_job.miny = W'(w_miny);
        n_job.maxy = W'(w_maxy);
    end

    // Hold the classified item until the queue takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else if (i_seg.ready) begin
            r_fv <= i_seg.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_job <= n_job;
        end
    end
endmodule

@@ hw/rtl/sbi_back.sv @@
module sbi_back
    import sbi_pkg::*;
#(
    parameter int W  = COORD_BITS_DEF,
    parameter int JW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [JW-1:0] i_job,
    output logic          o_pop,
    input  logic [W-1:0]  i_left,
    input  logic [W-1:0]  i_bottom,
    input  logic [W-2:0]  i_width,
    input  logic [W-2:0]  i_height,
    sbi_hit_if.source     o_hit
);
    localparam int A  = W + 1;
    localparam int H  = A / 2;
    localparam int NC = A + 2;

    typedef struct packed {
        logic [LANES-1:0]        ok;
        logic [LANES-1:0]        neg;
        logic [LANES-1:0][A-1:0] off;
        logic [LANES-1:0][W:0]   bnd;
        logic [A-1:0]            dxm;
        logic [A-1:0]            dym;
        logic [W-1:0]            sx;
        logic [W-1:0]            sy;
        logic [W-1:0]            minx;
        logic [W-1:0]            maxx;
        logic [W-1:0]            miny;
        logic [W-1:0]            maxy;
    } t_job;

    typedef struct packed {
        logic [W-1:0] minx;
        logic [W-1:0] maxx;
        logic [W-1:0] miny;
        logic [W-1:0] maxy;
    } t_span;

    t_job              w_job;
    logic              w_en;
    logic              r_cv   [NC];
    t_span             r_span [NC];
    logic signed [W+1:0] w_cx [LANES];
    logic signed [W+1:0] w_cy [LANES];
    logic [LANES-1:0]  w_lok;
    logic              r_ov;
    logic [1:0]        n_cnt;
    logic [W-1:0]      n_fx, n_fy, n_sx2, n_sy2;
    logic [1:0]        r_cnt;
    logic [W-1:0]      r_fx, r_fy, r_sx2, r_sy2;
    logic signed [W+1:0] w_l, w_r, w_b, w_t;
    logic signed [W+1:0] w_mnx, w_mxx, w_mny, w_mxy;

    assign w_job = t_job'(i_job);
    // The whole arithmetic pipe moves when the output register can take
    assign w_en  = !r_ov || o_hit.ready;
    assign o_pop = w_en;

    // Advance valid and span through the pipe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NC; s++) begin
                r_cv[s] <= 1'b0;
            end
        end else if (w_en) begin
            r_cv[0] <= i_valid;
            for (int s = 1; s < NC; s++) begin
                r_cv[s] <= r_cv[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_span[0] <= '{minx: w_job.minx, maxx: w_job.maxx,
                           miny: w_job.miny, maxy: w_job.maxy};
            for (int s = 1; s < NC; s++) begin
                r_span[s] <= r_span[s-1];
            end
        end
    end

    // One lane per edge candidate: multiply, then restoring division
    for (genvar g = 0; g < LANES; g++) begin : g_lane
        logic [A+H-1:0]     r_pl;
        logic [2*A-H-1:0]   r_ph;
        logic [A-1:0]       r_md;
        logic               r_mneg, r_mok;
        logic [W-1:0]       r_mso;
        logic [W:0]         r_mbnd;
        logic [2*A-1:0]     w_n;
        logic [A-1:0]       r_rem [A+1];
        logic [A-1:0]       r_low [A+1];
        logic [A-1:0]       r_q   [A+1];
        logic [A-1:0]       r_d   [A+1];
        logic               r_neg [A+1];
        logic               r_ok  [A+1];
        logic [W-1:0]       r_so  [A+1];
        logic [W:0]         r_bnd [A+1];
        logic [A:0]         w_t   [A+1];
        logic               w_ge  [A+1];
        logic [A-1:0]       w_om;
        logic signed [W+1:0] w_oth;

        assign w_om = (g < 2) ? w_job.dym : w_job.dxm;

        // Split product into two partial products
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_pl   <= w_job.off[g] * w_om[H-1:0];
                r_ph   <= w_job.off[g] * w_om[A-1:H];
                r_md   <= (g < 2) ? w_job.dxm : w_job.dym;
                r_mneg <= w_job.neg[g];
                r_mok  <= w_job.ok[g];
                r_mso  <= (g < 2) ? w_job.sy : w_job.sx;
                r_mbnd <= w_job.bnd[g];
            end
        end

        assign w_n = (2*A)'(r_pl) + ((2*A)'(r_ph) << H);

        assign w_t[0]  = '0;
        assign w_ge[0] = 1'b0;
        for (genvar j = 1; j <= A; j++) begin : g_step
            assign w_t[j]  = {r_rem[j-1], r_low[j-1][A-1]};
            assign w_ge[j] = (w_t[j] >= {1'b0, r_d[j-1]});
        end

        // Load the dividend, then one quotient bit per stage
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_rem[0] <= w_n[2*A-1:A];
                r_low[0] <= w_n[A-1:0];
                r_q[0]   <= '0;
                r_d[0]   <= r_md;
                r_neg[0] <= r_mneg;
                r_ok[0]  <= r_mok;
                r_so[0]  <= r_mso;
                r_bnd[0] <= r_mbnd;
                for (int j = 1; j <= A; j++) begin
                    r_rem[j] <= w_ge[j] ? A'(w_t[j] - {1'b0, r_d[j-1]}) : A'(w_t[j]);
                    r_low[j] <= {r_low[j-1][A-2:0], 1'b0};
                    r_q[j]   <= {r_q[j-1][A-2:0], w_ge[j]};
                    r_d[j]   <= r_d[j-1];
                    r_neg[j] <= r_neg[j-1];
                    r_ok[j]  <= r_ok[j-1];
                    r_so[j]  <= r_so[j-1];
                    r_bnd[j] <= r_bnd[j-1];
                end
            end
        end

        // Apply the sign of the step to the start coordinate
        assign w_oth = r_neg[A]
            ? $signed({{2{r_so[A][W-1]}}, r_so[A]}) - $signed({1'b0, r_q[A]})
            : $signed({{2{r_so[A][W-1]}}, r_so[A]}) + $signed({1'b0, r_q[A]});

        assign w_cx[g]  = (g < 2) ? $signed({r_bnd[A][W], r_bnd[A]}) : w_oth;
        assign w_cy[g]  = (g < 2) ? w_oth : $signed({r_bnd[A][W], r_bnd[A]});
        assign w_lok[g] = r_ok[A];
    end

    // Box and span bounds for the final test
    always_comb begin
        w_l   = $signed({{2{i_left[W-1]}}, i_left});
        w_r   = w_l + $signed({3'b000, i_width});
        w_b   = $signed({{2{i_bottom[W-1]}}, i_bottom});
        w_t   = w_b + $signed({3'b000, i_height});
        w_mnx = $signed({{2{r_span[NC-1].minx[W-1]}}, r_span[NC-1].minx});
        w_mxx = $signed({{2{r_span[NC-1].maxx[W-1]}}, r_span[NC-1].maxx});
        w_mny = $signed({{2{r_span[NC-1].miny[W-1]}}, r_span[NC-1].miny});
        w_mxy = $signed({{2{r_span[NC-1].maxy[W-1]}}, r_span[NC-1].maxy});
    end

    // Keep the first two candidates inside both box and span
    always_comb begin
        n_cnt = '0;
        n_fx  = '0;
        n_fy  = '0;
        n_sx2 = '0;
        n_sy2 = '0;
        for (int k = 0; k < LANES; k++) begin
            if (w_lok[k] && n_cnt != 2'd2
                && w_cx[k] >= w_l && w_cx[k] <= w_r
                && w_cy[k] >= w_b && w_cy[k] <= w_t
                && w_cx[k] >= w_mnx && w_cx[k] <= w_mxx
                && w_cy[k] >= w_mny && w_cy[k] <= w_mxy) begin
                if (n_cnt == 2'd0) begin
                    n_fx = W'(w_cx[k]);
                    n_fy = W'(w_cy[k]);
                end else begin
                    n_sx2 = W'(w_cx[k]);
                    n_sy2 = W'(w_cy[k]);
                end
                n_cnt = n_cnt + 2'd1;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_ov <= r_cv[NC-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cnt <= n_cnt;
            r_fx  <= n_fx;
            r_fy  <= n_fy;
            r_sx2 <= n_sx2;
            r_sy2 <= n_sy2;
        end
    end

    assign o_hit.valid       = r_ov;
    assign o_hit.point_count = r_cnt;
    assign o_hit.first_x     = r_fx;
    assign o_hit.first_y     = r_fy;
    assign o_hit.second_x    = r_sx2;
    assign o_hit.second_y    = r_sy2;
endmodule

@@ hw/rtl/segment_box_intersect_unit.sv @@
// Registers from input accept to result valid: classifier, queue, multiplier, divider, output.
// Throughput: one item per cycle while the result side is ready; the four crossing lanes each run a
// multiplier stage and a COORD_BITS + 1 stage pipelined restoring divider.
// A four-entry queue decouples the classifier from the arithmetic pipe.
// Reset (synchronous, active low) clears the box registers and all valids.
module segment_box_intersect_unit
    import sbi_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sbi_seg_if.sink   i_seg,
    sbi_cfg_if.sink   i_cfg,
    sbi_hit_if.source o_hit
);
    localparam int W  = COORD_BITS;
    localparam int A  = W + 1;
    localparam int JW = 2*LANES + LANES*A + LANES*(W+1) + 2*A + 6*W;

    logic [W-1:0]  r_left;
    logic [W-1:0]  r_bottom;
    logic [W-2:0]  r_width;
    logic [W-2:0]  r_height;
    logic          w_fv;
    logic [JW-1:0] w_fjob;
    logic          w_qnf;
    logic          w_qne;
    logic [JW-1:0] w_qjob;
    logic          w_pop;

    assign i_cfg.ready = 1'b1;

    // Box registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= '0;
            r_bottom <= '0;
            r_width  <= '0;
            r_height <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_BOX_LEFT:   r_left   <= i_cfg.data;
                REG_BOX_BOTTOM: r_bottom <= i_cfg.data;
                REG_BOX_WIDTH:  r_width  <= i_cfg.data[W-2:0];
                REG_BOX_HEIGHT: r_height <= i_cfg.data[W-2:0];
                default:        r_left   <= r_left;
            endcase
        end
    end

    sbi_front #(.W(W), .JW(JW)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_seg    (i_seg),
        .i_left   (r_left),
        .i_bottom (r_bottom),
        .i_width  (r_width),
        .i_height (r_height),
        .o_valid  (w_fv),
        .o_job    (w_fjob),
        .i_ready  (w_qnf)
    );

    sbi_queue #(.DW(JW), .DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_fv),
        .i_data      (w_fjob),
        .o_not_full  (w_qnf),
        .i_pop       (w_pop),
        .o_not_empty (w_qne),
        .o_data      (w_qjob)
    );

    sbi_back #(.W(W), .JW(JW)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_qne),
        .i_job    (w_qjob),
        .o_pop    (w_pop),
        .i_left   (r_left),
        .i_bottom (r_bottom),
        .i_width  (r_width),
        .i_height (r_height),
        .o_hit    (o_hit)
    );
endmodule

@@ hw/rtl/sbi_check.sv @@
module sbi_check
    import sbi_pkg::*;
#(
    parameter int W = COORD_BITS_DEF
) (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_valid,
    input logic         i_ready,
    input logic [1:0]   i_count,
    input logic [W-1:0] i_fx,
    input logic [W-1:0] i_fy,
    input logic [W-1:0] i_sx,
    input logic [W-1:0] i_sy
);
    // Reset empties the output
    a_reset_clear: assert property (@(posedge i_clk) !i_rst_n |=> !i_valid)
        else $error("result valid after reset");

    // Count never exceeds two
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_count != 2'd3))
        else $error("point count above two");

    // No point means zero first point
    a_first_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_count == 2'd0) |-> (i_fx == '0 && i_fy == '0))
        else $error("first point set with zero count");

    // Fewer than two means zero second point
    a_second_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_count != 2'd2) |-> (i_sx == '0 && i_sy == '0))
        else $error("second point set with count below two");

    // Stalled item stays valid with its count and first x held
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_ready) |=> (i_valid && $stable(i_count) && $stable(i_fx)))
        else $error("stalled item changed");
endmodule

bind segment_box_intersect_unit sbi_check #(.W(COORD_BITS)) u_sbi_check (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_hit.valid),
    .i_ready (o_hit.ready),
    .i_count (o_hit.point_count),
    .i_fx    (o_hit.first_x),
    .i_fy    (o_hit.first_y),
    .i_sx    (o_hit.second_x),
    .i_sy    (o_hit.second_y)
);

@@ test/sbi_checker.sv @@
`timescale 1ns / 1ps

module sbi_checker
    import sbi_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    sbi_seg_if   seg,
    sbi_cfg_if   cfg,
    sbi_hit_if   hit,
    output int   o_errors,
    output int   o_pending
);

    typedef struct packed {
        logic [1:0]  point_count;
        logic [31:0] first_x;
        logic [31:0] first_y;
        logic [31:0] second_x;
        logic [31:0] second_y;
    } crossing_t;

    // Box as written through the register port
    logic [31:0] box_left_q;
    logic [31:0] box_bottom_q;
    logic [30:0] box_width_q;
    logic [30:0] box_height_q;

    crossing_t crossings_due[$];

    function automatic longint unsigned magnitude(longint v);
        return (v < 0) ? longint'(0) - v : v;
    endfunction

    // Other-axis coordinate where the segment meets the line along == e
    function automatic longint meet_coord(longint s_a, longint d_a, longint s_o,
                                          longint d_o, longint e);
        longint         off;
        logic   [127:0] prod;
        logic   [63:0]  quot;
        bit             neg;
        off  = e - s_a;
        prod = 128'(magnitude(off)) * 128'(magnitude(d_o));
        quot = 64'(prod / 128'(magnitude(d_a)));
        neg  = ((off < 0) != (d_o < 0)) != (d_a < 0);
        return neg ? s_o - longint'(quot) : s_o + longint'(quot);
    endfunction

    function automatic crossing_t box_crossings(logic [31:0] i_sx, logic [31:0] i_sy,
                                                logic [31:0] i_ex, logic [31:0] i_ey);
        longint    sx, sy, ex, ey, lft, bot, rgt, tp;
        longint    minx, maxx, miny, maxy, dx, dy;
        longint    cx[4];
        longint    cy[4];
        bit        hit_ok[4];
        longint    px[2];
        longint    py[2];
        int        cnt;
        crossing_t res;
        sx = longint'(signed'(i_sx));
        sy = longint'(signed'(i_sy));
        ex = longint'(signed'(i_ex));
        ey = longint'(signed'(i_ey));
        lft = longint'(signed'(box_left_q));
        bot = longint'(signed'(box_bottom_q));
        rgt = lft + longint'(box_width_q);
        tp  = bot + longint'(box_height_q);
        minx = (sx < ex) ? sx : ex;
        maxx = (sx > ex) ? sx : ex;
        miny = (sy < ey) ? sy : ey;
        maxy = (sy > ey) ? sy : ey;
        dx = ex - sx;
        dy = ey - sy;
        cnt = 0;
        px = '{0, 0};
        py = '{0, 0};
        for (int k = 0; k < 4; k++) begin
            hit_ok[k] = 0;
            cx[k] = 0;
            cy[k] = 0;
        end
        // Cut against left and right edges
        if (dx != 0) begin
            cx[0] = lft;
            cx[1] = rgt;
            for (int k = 0; k < 2; k++) begin
                if (cx[k] >= minx && cx[k] <= maxx) begin
                    cy[k] = meet_coord(sx, dx, sy, dy, cx[k]);
                    hit_ok[k] = 1;
                end
            end
        end
        // Cut against bottom and top edges
        if (dy != 0) begin
            cy[2] = bot;
            cy[3] = tp;
            for (int k = 2; k < 4; k++) begin
                if (cy[k] >= miny && cy[k] <= maxy) begin
                    cx[k] = meet_coord(sy, dy, sx, dx, cy[k]);
                    hit_ok[k] = 1;
                end
            end
        end
        // Keep the first two candidates inside both box and span
        for (int k = 0; k < 4; k++) begin
            if (cnt < 2 && hit_ok[k] &&
                cx[k] >= lft && cx[k] <= rgt && cy[k] >= bot && cy[k] <= tp &&
                cx[k] >= minx && cx[k] <= maxx && cy[k] >= miny && cy[k] <= maxy) begin
                px[cnt] = cx[k];
                py[cnt] = cy[k];
                cnt++;
            end
        end
        res.point_count = cnt[1:0];
        res.first_x  = px[0][31:0];
        res.first_y  = py[0][31:0];
        res.second_x = px[1][31:0];
        res.second_y = py[1][31:0];
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t: %s mismatch: got %h, want %h", $realtime, what, got, want);
        o_errors++;
    endtask

    // Track registers, predict on each segment, compare on each result
    always @(posedge i_clk) begin
        crossing_t want;
        if (!i_rst_n) begin
            box_left_q   <= '0;
            box_bottom_q <= '0;
            box_width_q  <= '0;
            box_height_q <= '0;
            crossings_due.delete();
        end else begin
            if (cfg.valid && cfg.ready) begin
                case (cfg.index)
                    REG_BOX_LEFT:   box_left_q   <= cfg.data;
                    REG_BOX_BOTTOM: box_bottom_q <= cfg.data;
                    REG_BOX_WIDTH:  box_width_q  <= cfg.data[30:0];
                    REG_BOX_HEIGHT: box_height_q <= cfg.data[30:0];
                    default: ;
                endcase
            end
            if (seg.valid && seg.ready)
                crossings_due.push_back(box_crossings(seg.start_x, seg.start_y,
                                                      seg.end_x, seg.end_y));
            if (hit.valid && hit.ready) begin
                if (crossings_due.size() == 0) begin
                    $display("%0t: result with nothing expected", $realtime);
                    o_errors++;
                end else begin
                    want = crossings_due.pop_front();
                    if (hit.point_count !== want.point_count)
                        report_mismatch("point_count", 32'(hit.point_count),
                                        32'(want.point_count));
                    if (hit.first_x !== want.first_x)
                        report_mismatch("first_x", hit.first_x, want.first_x);
                    if (hit.first_y !== want.first_y)
                        report_mismatch("first_y", hit.first_y, want.first_y);
                    if (hit.second_x !== want.second_x)
                        report_mismatch("second_x", hit.second_x, want.second_x);
                    if (hit.second_y !== want.second_y)
                        report_mismatch("second_y", hit.second_y, want.second_y);
                end
            end
        end
        o_pending = crossings_due.size();
    end

    initial o_errors = 0;
    initial o_pending = 0;

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import sbi_pkg::*;

    localparam int LATENCY     = 37;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RAND_ITEMS  = 1600;
    localparam int BOXES       = 7;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   cycles;
    bit   quiet;

    sbi_seg_if #(32) seg_if ();
    sbi_cfg_if #(32) cfg_if ();
    sbi_hit_if #(32) hit_if ();

    segment_box_intersect_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_seg   (seg_if),
        .i_cfg   (cfg_if),
        .o_hit   (hit_if)
    );

    sbi_checker u_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .seg       (seg_if),
        .cfg       (cfg_if),
        .hit       (hit_if),
        .o_errors  (fail_count),
        .o_pending (pending)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Current box, mirrored for shaping stimulus
    logic [31:0] cur_left;
    logic [31:0] cur_bottom;
    logic [30:0] cur_width;
    logic [30:0] cur_height;

    // Stall the result side in random bursts
    int stall_left;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hit_if.ready <= 1'b0;
            stall_left   <= 0;
        end else if (quiet) begin
            hit_if.ready <= 1'b1;
        end else if (stall_left > 0) begin
            hit_if.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end else if ($urandom_range(0, 5) == 0) begin
            hit_if.ready <= 1'b0;
            stall_left   <= $urandom_range(0, 6);
        end else begin
            hit_if.ready <= 1'b1;
        end
    end

    // Abort on a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
    endtask

    // Drain the pipe, then load a new box
    task automatic load_box(logic [31:0] lft, logic [31:0] bot, logic [30:0] w,
                            logic [30:0] h);
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
        cur_left   = lft;
        cur_bottom = bot;
        cur_width  = w;
        cur_height = h;
        // Top data bit beyond the extent fields is random and must be dropped
        write_reg(REG_BOX_LEFT, lft);
        write_reg(REG_BOX_BOTTOM, bot);
        write_reg(REG_BOX_WIDTH, {1'($urandom), w});
        write_reg(REG_BOX_HEIGHT, {1'($urandom), h});
    endtask

    task automatic send_segment(logic [31:0] sx, logic [31:0] sy, logic [31:0] ex,
                                logic [31:0] ey);
        seg_if.valid   <= 1'b1;
        seg_if.start_x <= sx;
        seg_if.start_y <= sy;
        seg_if.end_x   <= ex;
        seg_if.end_y   <= ey;
        do @(posedge i_clk); while (!seg_if.ready);
        // Hold valid high unless a gap follows
        if (!quiet && $urandom_range(0, 4) == 0) begin
            seg_if.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
    endtask

    // Coordinate near an edge of the box, or anywhere now and then
    function automatic logic [31:0] near_box(logic [31:0] base, logic [30:0] extent);
        logic [31:0] spread;
        spread = 32'(1) << $urandom_range(0, 31);
        case ($urandom_range(0, 4))
            0: return base;
            1: return base + 32'(extent);
            2: return base + 32'($urandom_range(0, 32'(extent)));
            3: return base - ($urandom & (spread - 1)) + ($urandom & (spread - 1));
            default: return $urandom;
        endcase
    endfunction

    task automatic directed_items();
        // Box at (1,1), extent 2.0 in each axis
        send_segment(32'h0000_0000, 32'h0002_0000, 32'h0004_0000, 32'h0002_0000);
        send_segment(32'h0004_0000, 32'h0002_0000, 32'h0000_0000, 32'h0002_0000);
        send_segment(32'h0002_0000, 32'h0000_0000, 32'h0002_0000, 32'h0004_0000);
        send_segment(32'h0002_0000, 32'h0004_0000, 32'h0002_0000, 32'h0000_0000);
        // Diagonal through both corners: four candidates, two kept
        send_segment(32'h0000_0000, 32'h0000_0000, 32'h0004_0000, 32'h0004_0000);
        send_segment(32'h0004_0000, 32'h0004_0000, 32'h0000_0000, 32'h0000_0000);
        // Degenerate segment
        send_segment(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        send_segment(32'h0002_0000, 32'h0002_0000, 32'h0002_0000, 32'h0002_0000);
        // Inside only, outside only, one crossing
        send_segment(32'h0001_8000, 32'h0001_8000, 32'h0002_8000, 32'h0002_0000);
        send_segment(32'h0005_0000, 32'h0005_0000, 32'h0007_0000, 32'h0006_0000);
        send_segment(32'h0002_0000, 32'h0002_0000, 32'h0005_0000, 32'h0002_1234);
        // Inexact quotients, both signs
        send_segment(32'h0000_0001, 32'h0000_0003, 32'h0003_0007, 32'h0004_0001);
        send_segment(32'h0003_0007, 32'h0000_0003, 32'h0000_0001, 32'h0004_0001);
        // Coordinate extremes
        send_segment(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_segment(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        send_segment(32'h8000_0000, 32'h0002_0000, 32'h7FFF_FFFF, 32'h0002_0001);
        send_segment(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
        send_segment(32'h0001_0000, 32'h8000_0000, 32'h0001_0000, 32'h7FFF_FFFF);
        send_segment(32'h8000_0000, 32'h0003_0000, 32'h7FFF_FFFF, 32'h0003_0000);
    endtask

    initial begin
        logic [31:0] boxes[BOXES][4];
        int          per_box;
        boxes[0] = '{32'h0001_0000, 32'h0001_0000, 32'h0002_0000, 32'h0002_0000};
        boxes[1] = '{32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
        boxes[2] = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
        boxes[3] = '{32'hFFF0_0000, 32'h0000_8000, 32'h0000_0000, 32'h0030_0000};
        boxes[4] = '{32'h1234_5678, 32'hF000_0000, 32'h0100_0000, 32'h0000_0000};
        boxes[5] = '{32'hC000_0000, 32'h4000_0000, 32'h0000_0001, 32'h7FFF_FFFF};
        boxes[6] = '{32'hFFFE_0000, 32'hFFFD_0000, 32'h0005_0000, 32'h0003_0000};
        per_box = RAND_ITEMS / (BOXES + 1);
        quiet          = 1'b0;
        cycles         = 0;
        i_rst_n        <= 1'b0;
        seg_if.valid   <= 1'b0;
        seg_if.start_x <= '0;
        seg_if.start_y <= '0;
        seg_if.end_x   <= '0;
        seg_if.end_y   <= '0;
        cfg_if.valid   <= 1'b0;
        cfg_if.index   <= REG_BOX_LEFT;
        cfg_if.data    <= '0;
        cur_left   = '0;
        cur_bottom = '0;
        cur_width  = '0;
        cur_height = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // Point box at the origin straight out of reset
        for (int n = 0; n < per_box; n++)
            send_segment(near_box(0, 0), near_box(0, 0), near_box(0, 0), near_box(0, 0));
        seg_if.valid <= 1'b0;
        for (int b = 0; b < BOXES; b++) begin
            load_box(boxes[b][0], boxes[b][1], boxes[b][2][30:0], boxes[b][3][30:0]);
            if (b == 0)
                directed_items();
            if (b == BOXES - 1)
                quiet = 1'b1;
            for (int n = 0; n < per_box; n++) begin
                if ($urandom_range(0, 3) == 0)
                    send_segment($urandom, $urandom, $urandom, $urandom);
                else
                    send_segment(near_box(cur_left, cur_width),
                                 near_box(cur_bottom, cur_height),
                                 near_box(cur_left, cur_width),
                                 near_box(cur_bottom, cur_height));
            end
            seg_if.valid <= 1'b0;
        end
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (fail_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/sbi_pkg.sv
hw/rtl/sbi_if.sv
hw/rtl/sbi_queue.sv
hw/rtl/sbi_front.sv
hw/rtl/sbi_back.sv
hw/rtl/segment_box_intersect_unit.sv
hw/rtl/sbi_check.sv
test/sbi_checker.sv
test/tb_top.sv
